@@ sv/ipsvpwm_pkg.sv @@
// Package for the inverse Park / space-vector PWM block.
// Holds duty width, fixed-point constants, register indexes, sextant codes
// and the quarter-wave sine generator used to build the lookup.
package ipsvpwm_pkg;

	localparam int DUTY_W = 40;
	localparam int DIV_W  = 33;
	localparam int REM_W  = 17;

	localparam logic [1:0] REG_SUPPLY  = 2'd0;
	localparam logic [1:0] REG_PERIOD  = 2'd1;
	localparam logic [1:0] REG_CEILING = 2'd2;

	localparam logic [15:0] SUPPLY_RST  = 16'd12000;
	localparam logic [15:0] PERIOD_RST  = 16'd1000;
	localparam logic [15:0] CEILING_RST = 16'd58982;

	localparam logic signed [DUTY_W-1:0] Q16_ONE = 40'sd65536;
	localparam logic signed [31:0] INV_SQRT3_Q30     = 32'sd619925131;
	localparam logic signed [31:0] TWO_INV_SQRT3_Q30 = 32'sd1239850262;

	localparam logic [2:0] SEXT_1 = 3'd0;
	localparam logic [2:0] SEXT_2 = 3'd1;
	localparam logic [2:0] SEXT_3 = 3'd2;
	localparam logic [2:0] SEXT_4 = 3'd3;
	localparam logic [2:0] SEXT_5 = 3'd4;
	localparam logic [2:0] SEXT_6 = 3'd5;

	// Q30 sine of a quarter-turn offset r (16384 = pi/2), Taylor in Horner form
	function automatic logic [30:0] quarter_sine(input logic [14:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = (64'(r) * 64'd1686629713) >> 14;
		x2 = (x * x) >> 30;
		t  = 64'd1073741824 - x2 / 64'd72;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		if (s > 64'd1073741824) begin
			s = 64'd1073741824;
		end
		return s[30:0];
	endfunction

endpackage

@@ sv/inverse_park_space_vector_pwm.sv @@
// Inverse Park transform and centred space-vector PWM, fully pipelined.
// Depends on ipsvpwm_pkg for constants, codes and the sine generator.
//
// channel  | direction | ports                                   | handshake
// command  | in        | volt_d, volt_q, rotor_angle             | start && !busy
// result   | out       | compare_a/b/c, sextant, in_linear_range | done, one cycle
// config   | in        | cfg_index, cfg_data                     | cfg_write
//
// A word may enter every cycle while busy is low; its result passes through one
// entry stage, 33 stages of the restoring divider, eight arithmetic stages and
// the output register. The divider depth sets the latency.
// Reset clears the valid chain and loads the register defaults; busy is high
// only while reset is applied and the cycle after. Results cannot be stalled.
module inverse_park_space_vector_pwm #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] volt_d,
	input  logic signed [15:0] volt_q,
	input  logic        [15:0] rotor_angle,
	input  logic               cfg_write,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data,
	output logic               done,
	output logic        [15:0] compare_a,
	output logic        [15:0] compare_b,
	output logic        [15:0] compare_c,
	output logic        [2:0]  sextant,
	output logic               in_linear_range
);

	localparam int SH     = 16 - SINE_TABLE_BITS;
	localparam int QBITS  = SINE_TABLE_BITS - 2;
	localparam int QN     = (1 << QBITS) + 1;
	localparam int NQ     = ipsvpwm_pkg::DIV_W;
	localparam int DW     = ipsvpwm_pkg::DUTY_W;
	localparam int RW     = ipsvpwm_pkg::REM_W;
	localparam int LAT    = NQ + 10;

	// configuration
	logic [15:0] supply_q, period_q, ceil_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= ipsvpwm_pkg::SUPPLY_RST;
			period_q <= ipsvpwm_pkg::PERIOD_RST;
			ceil_q   <= ipsvpwm_pkg::CEILING_RST;
			busy_q   <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					ipsvpwm_pkg::REG_SUPPLY:  supply_q <= cfg_data;
					ipsvpwm_pkg::REG_PERIOD:  period_q <= cfg_data;
					ipsvpwm_pkg::REG_CEILING: ceil_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign busy = busy_q;

	logic        accept;
	logic [RW-1:0] dvs;
	assign accept = start && !busy_q;
	assign dvs    = (supply_q == 16'd0) ? RW'(2) : {supply_q, 1'b0};

	// quarter-wave sine table
	logic [30:0] qs_tab [QN];
	for (genvar g = 0; g < QN; g++) begin : g_qs
		assign qs_tab[g] = ipsvpwm_pkg::quarter_sine(15'(g << SH));
	end

	// entry stage
	logic                       v_s1, negd_s1, negq_s1;
	logic [NQ-1:0]              numd_s1, numq_s1;
	logic [SINE_TABLE_BITS-1:0] ang_s1;
	logic [15:0]                magd, magq;

	assign magd = volt_d[15] ? 16'(17'd65536 - 17'(volt_d)) : volt_d;
	assign magq = volt_q[15] ? 16'(17'd65536 - 17'(volt_q)) : volt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		negd_s1 <= volt_d[15];
		negq_s1 <= volt_q[15];
		numd_s1 <= {17'(magd) + {magd, 1'b0}, 16'd0};
		numq_s1 <= {17'(magq) + {magq, 1'b0}, 16'd0};
		ang_s1  <= rotor_angle[15:SH];
	end

	// sine and cosine lookup
	logic [1:0]       quad, cquad;
	logic [QBITS:0]   idx_up, idx_dn;
	logic [30:0]      sn_mag, cs_mag;
	logic signed [31:0] sn_lk, cs_lk;

	always_comb begin
		quad   = ang_s1[SINE_TABLE_BITS-1 -: 2];
		cquad  = quad + 2'd1;
		idx_up = {1'b0, ang_s1[QBITS-1:0]};
		idx_dn = (QBITS+1)'(1 << QBITS) - idx_up;
		sn_mag = quad[0]  ? qs_tab[idx_dn] : qs_tab[idx_up];
		cs_mag = cquad[0] ? qs_tab[idx_dn] : qs_tab[idx_up];
		sn_lk  = quad[1]  ? -$signed({1'b0, sn_mag}) : $signed({1'b0, sn_mag});
		cs_lk  = cquad[1] ? -$signed({1'b0, cs_mag}) : $signed({1'b0, cs_mag});
	end

	// restoring divider pipeline, one quotient bit per stage
	logic               vld_s  [NQ+1];
	logic               negd_s [NQ+1];
	logic               negq_s [NQ+1];
	logic [RW-1:0]      remd_s [NQ+1];
	logic [RW-1:0]      remq_s [NQ+1];
	logic [NQ-1:0]      dqd_s  [NQ+1];
	logic [NQ-1:0]      dqq_s  [NQ+1];
	logic signed [31:0] sn_s   [NQ+1];
	logic signed [31:0] cs_s   [NQ+1];

	assign vld_s[0]  = v_s1;
	assign negd_s[0] = negd_s1;
	assign negq_s[0] = negq_s1;
	assign remd_s[0] = '0;
	assign remq_s[0] = '0;
	assign dqd_s[0]  = numd_s1;
	assign dqq_s[0]  = numq_s1;
	assign sn_s[0]   = sn_lk;
	assign cs_s[0]   = cs_lk;

	for (genvar k = 1; k <= NQ; k++) begin : g_div
		logic [RW:0] td, tq;
		logic        ged, geq;

		always_comb begin
			td  = {remd_s[k-1], dqd_s[k-1][NQ-1]};
			tq  = {remq_s[k-1], dqq_s[k-1][NQ-1]};
			ged = td >= {1'b0, dvs};
			geq = tq >= {1'b0, dvs};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			remd_s[k] <= ged ? RW'(td - {1'b0, dvs}) : td[RW-1:0];
			remq_s[k] <= geq ? RW'(tq - {1'b0, dvs}) : tq[RW-1:0];
			dqd_s[k]  <= {dqd_s[k-1][NQ-2:0], ged};
			dqq_s[k]  <= {dqq_s[k-1][NQ-2:0], geq};
			negd_s[k] <= negd_s[k-1];
			negq_s[k] <= negq_s[k-1];
			sn_s[k]   <= sn_s[k-1];
			cs_s[k]   <= cs_s[k-1];
		end
	end

	// arithmetic stages
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [33:0] modd_s2, modq_s2;
	logic signed [31:0] sn_s2, cs_s2;
	logic signed [65:0] pdc_s3, pqs_s3, pds_s3, pqc_s3;
	logic signed [35:0] alpha_s4, beta_s4;
	logic signed [35:0] alpha_s5;
	logic signed [DW-1:0] kb_s5, k2_s5;
	logic [2:0]           sext_s6, sext_s7, sext_s8, sext_s9;
	logic signed [DW-1:0] ta_s6, tb_s6;
	logic signed [DW-1:0] base_s7, first_s7, sum_s7;
	logic signed [DW-1:0] ua_s8, ub_s8, uc_s8;
	logic [15:0]          da_s9, db_s9, dc_s9;
	logic                 lin_s9;

	logic signed [DW-1:0] alpha_x, kb_x, k2_x;
	logic [2:0]           sext_x;
	logic signed [DW-1:0] ta_x, tb_x;
	logic signed [DW-1:0] ua_x, ub_x, uc_x, mid_x, top_x;
	logic signed [67:0]   kbp, k2p;

	assign kbp = beta_s4 * ipsvpwm_pkg::INV_SQRT3_Q30;
	assign k2p = beta_s4 * ipsvpwm_pkg::TWO_INV_SQRT3_Q30;

	always_comb begin
		alpha_x = DW'(alpha_s5);
		kb_x    = kb_s5;
		k2_x    = k2_s5;
		if (!kb_x[DW-1]) begin
			if (!alpha_x[DW-1]) begin
				sext_x = (kb_x > alpha_x) ? ipsvpwm_pkg::SEXT_2 : ipsvpwm_pkg::SEXT_1;
			end else begin
				sext_x = (-kb_x > alpha_x) ? ipsvpwm_pkg::SEXT_3 : ipsvpwm_pkg::SEXT_2;
			end
		end else begin
			if (!alpha_x[DW-1]) begin
				sext_x = (-kb_x > alpha_x) ? ipsvpwm_pkg::SEXT_5 : ipsvpwm_pkg::SEXT_6;
			end else begin
				sext_x = (kb_x > alpha_x) ? ipsvpwm_pkg::SEXT_4 : ipsvpwm_pkg::SEXT_5;
			end
		end
		case (sext_x)
			ipsvpwm_pkg::SEXT_1: begin ta_x = alpha_x - kb_x;  tb_x = k2_x;            end
			ipsvpwm_pkg::SEXT_2: begin ta_x = alpha_x + kb_x;  tb_x = kb_x - alpha_x;  end
			ipsvpwm_pkg::SEXT_3: begin ta_x = k2_x;            tb_x = -alpha_x - kb_x; end
			ipsvpwm_pkg::SEXT_4: begin ta_x = kb_x - alpha_x;  tb_x = -k2_x;           end
			ipsvpwm_pkg::SEXT_5: begin ta_x = -alpha_x - kb_x; tb_x = alpha_x - kb_x;  end
			default:             begin ta_x = -k2_x;           tb_x = alpha_x + kb_x;  end
		endcase
	end

	always_comb begin
		mid_x = base_s7 + first_s7;
		top_x = base_s7 + sum_s7;
		case (sext_s7)
			ipsvpwm_pkg::SEXT_1: begin ua_x = base_s7; ub_x = mid_x;   uc_x = top_x;   end
			ipsvpwm_pkg::SEXT_2: begin ub_x = base_s7; ua_x = mid_x;   uc_x = top_x;   end
			ipsvpwm_pkg::SEXT_3: begin ub_x = base_s7; uc_x = mid_x;   ua_x = top_x;   end
			ipsvpwm_pkg::SEXT_4: begin uc_x = base_s7; ub_x = mid_x;   ua_x = top_x;   end
			ipsvpwm_pkg::SEXT_5: begin uc_x = base_s7; ua_x = mid_x;   ub_x = top_x;   end
			default:             begin ua_x = base_s7; uc_x = mid_x;   ub_x = top_x;   end
		endcase
	end

	function automatic logic [15:0] clamp_duty(input logic signed [DW-1:0] u,
			input logic [15:0] ceil);
		logic [15:0] d;
		if (u[DW-1]) begin
			d = 16'd0;
		end else if (u > $signed({{(DW-16){1'b0}}, ceil})) begin
			d = ceil;
		end else begin
			d = u[15:0];
		end
		return d;
	endfunction

	function automatic logic in_unit(input logic signed [DW-1:0] u);
		return !u[DW-1] && (u <= ipsvpwm_pkg::Q16_ONE);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s2 <= vld_s[NQ];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			done <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		modd_s2 <= negd_s[NQ] ? -$signed({2'b0, dqd_s[NQ][31:0]})
		                      : $signed({2'b0, dqd_s[NQ][31:0]});
		modq_s2 <= negq_s[NQ] ? -$signed({2'b0, dqq_s[NQ][31:0]})
		                      : $signed({2'b0, dqq_s[NQ][31:0]});
		sn_s2   <= sn_s[NQ];
		cs_s2   <= cs_s[NQ];

		pdc_s3 <= modd_s2 * cs_s2;
		pqs_s3 <= modq_s2 * sn_s2;
		pds_s3 <= modd_s2 * sn_s2;
		pqc_s3 <= modq_s2 * cs_s2;

		alpha_s4 <= 36'((pdc_s3 - pqs_s3) >>> 30);
		beta_s4  <= 36'((pds_s3 + pqc_s3) >>> 30);

		alpha_s5 <= alpha_s4;
		kb_s5    <= DW'(kbp >>> 30);
		k2_s5    <= DW'(k2p >>> 30);

		sext_s6 <= sext_x;
		ta_s6   <= ta_x;
		tb_s6   <= tb_x;

		sext_s7  <= sext_s6;
		base_s7  <= (ipsvpwm_pkg::Q16_ONE - ta_s6 - tb_s6) >>> 1;
		first_s7 <= (sext_s6[0] == 1'b0) ? ta_s6 : tb_s6;
		sum_s7   <= ta_s6 + tb_s6;

		sext_s8 <= sext_s7;
		ua_s8   <= ua_x;
		ub_s8   <= ub_x;
		uc_s8   <= uc_x;

		sext_s9 <= sext_s8;
		da_s9   <= clamp_duty(ua_s8, ceil_q);
		db_s9   <= clamp_duty(ub_s8, ceil_q);
		dc_s9   <= clamp_duty(uc_s8, ceil_q);
		lin_s9  <= in_unit(ua_s8) && in_unit(ub_s8) && in_unit(uc_s8);

		compare_a       <= 16'((32'(da_s9) * 32'(period_q)) >> 16);
		compare_b       <= 16'((32'(db_s9) * 32'(period_q)) >> 16);
		compare_c       <= 16'((32'(dc_s9) * 32'(period_q)) >> 16);
		sextant         <= sext_s9;
		in_linear_range <= lin_s9;
	end

	a_sextant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sextant <= ipsvpwm_pkg::SEXT_6))
		else $error("sextant out of range");

	a_compare_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (compare_a <= period_q && compare_b <= period_q && compare_c <= period_q))
		else $error("compare above period");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept, LAT))
		else $error("result strobe out of step with accepted words");

endmodule
